// File: hw/rtl/lzwd_pkg.sv
`default_nettype none
package lzwd_pkg;

  // history window and copy limits
  localparam int HIST_DEPTH = 4096;
  localparam int MAX_COPY   = 18;

  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int PC_W    = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W   = $clog2(MAX_COPY + 1);
  localparam int OFF_W   = 12;
  localparam int TMP_W   = OFF_W + 2;

  localparam logic [7:0] MAGIC_BYTE  = 8'hAB;
  localparam logic [7:0] OFF_HI_MASK = 8'h0F;
  localparam int         MIN_MATCH   = 3;
  localparam int         RESULT_LIMIT = 18;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // result status codes
  localparam logic [2:0] ST_DATA       = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_BAD_HEADER = 3'd5;

  // configuration register indexes
  localparam logic [0:0] REG_EXPECT_HEADER = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LIT  = 2'd1,
    OP_COPY = 2'd2,
    OP_STAT = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_last;
  } out_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       lit;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
    logic [2:0]       status;
    logic             stream_end;
  } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/lz_window_decompressor.sv
// LZSS decompressor with a 4 KiB history window.
// Input channel (in_valid / in_stall / in_data) takes one compressed byte per
// beat; stream_end marks the last byte of a stream. Output channel (out_valid /
// out_stall / out_data) gives one result per beat: a data byte or a status
// code, with run_last set on the final result caused by an input byte.
// A front parser classifies each byte combinationally and queues a command in a
// four-entry queue; a back engine executes commands against the history RAM.
// Each result is registered in the command queue and then in the output beat
// register; a copy token's bytes also pass through the history RAM read register.
// Throughput: one byte per cycle for literal bytes while out_stall is low; a copy
// holds the back engine for the command pop, one read ahead, then one history RAM
// read per output byte, and the input stalls once the command queue fills behind
// it.
// Write expect_header via the APB port, address 0, only while idle; not enforced.
// Reset (synchronous, rst_n low) clears all control state and starts a fresh
// stream; the history RAM is not cleared since offsets never reach unwritten
// bytes. When out_stall is high the output beat holds and the back engine waits.
`default_nettype none
module lz_window_decompressor
  import lzwd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic expect_header_r;
  logic cfg_wr;

  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_head;
  logic q_full;
  logic q_empty;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EXPECT_HEADER);
  assign prdata = (paddr[2] == REG_EXPECT_HEADER) ? {31'b0, expect_header_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b0;
    end else if (cfg_wr) begin
      expect_header_r <= pwdata[0];
    end
  end

  lzwd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .expect_header (expect_header_r),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (q_push_cmd)
  );

  lzwd_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lzwd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_cmd_fifo.sv
`default_nettype none
module lzwd_cmd_fifo
  import lzwd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_front.sv
`default_nettype none
module lzwd_front
  import lzwd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic expect_header,
  input  wire logic in_valid,
  input  wire in_t  in_data,
  output logic      in_stall,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      push_cmd
);

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_FLAG    = 5'b00010,
    PH_TOKEN   = 5'b00100,
    PH_OFF_LOW = 5'b01000,
    PH_LEN     = 5'b10000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [2:0]      tok_idx_r, tok_idx_nxt;
  logic [3:0]      off_hi_r, off_hi_nxt;
  logic [7:0]      off_lo_r, off_lo_nxt;
  logic            rejected_r, rejected_nxt;
  logic [PC_W-1:0] produced_r, produced_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             last_byte;
  logic [OFF_W-1:0] off;
  logic             off_bad;
  logic [LEN_W-1:0] add_amt;
  logic             add_en;
  logic [PC_W:0]    psum;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign b         = in_data.in_byte;
  assign last_byte = in_data.stream_end;
  assign off       = {off_hi_r, off_lo_r};
  assign off_bad   = (off == '0) || (TMP_W'(off) > TMP_W'(produced_r));
  assign psum      = (PC_W+1)'(produced_r) + (PC_W+1)'(add_amt);

  // token parser: classify each byte into a command for the back end
  always_comb begin
    phase_nxt    = phase_r;
    flags_nxt    = flags_r;
    tok_idx_nxt  = tok_idx_r;
    off_hi_nxt   = off_hi_r;
    off_lo_nxt   = off_lo_r;
    rejected_nxt = rejected_r;
    produced_nxt = produced_r;
    add_amt      = '0;
    add_en       = 1'b0;
    push_cmd     = '{op: OP_NONE, lit: b, len: '0, off: off, status: ST_DATA,
                     stream_end: last_byte};

    if (!rejected_r) begin
      case (phase_r)
        PH_START: begin
          if (expect_header) begin
            if (b == MAGIC_BYTE) begin
              phase_nxt = PH_FLAG;
            end else begin
              push_cmd.op     = OP_STAT;
              push_cmd.status = ST_BAD_HEADER;
              rejected_nxt    = 1'b1;
            end
          end else begin
            flags_nxt   = b;
            tok_idx_nxt = '0;
            phase_nxt   = PH_TOKEN;
          end
        end
        PH_FLAG: begin
          flags_nxt   = b;
          tok_idx_nxt = '0;
          phase_nxt   = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flags_r[tok_idx_r]) begin
            off_hi_nxt = 4'(b & OFF_HI_MASK);
            phase_nxt  = PH_OFF_LOW;
            if (last_byte) begin
              push_cmd.op     = OP_STAT;
              push_cmd.status = ST_TRUNCATED;
            end
          end else begin
            push_cmd.op = OP_LIT;
            add_amt     = LEN_W'(1);
            add_en      = 1'b1;
            if (tok_idx_r == 3'd7) begin
              tok_idx_nxt = '0;
              phase_nxt   = PH_FLAG;
            end else begin
              tok_idx_nxt = tok_idx_r + 1'b1;
              phase_nxt   = PH_TOKEN;
            end
          end
        end
        PH_OFF_LOW: begin
          off_lo_nxt = b;
          phase_nxt  = PH_LEN;
          if (last_byte) begin
            push_cmd.op     = OP_STAT;
            push_cmd.status = ST_TRUNCATED;
          end
        end
        PH_LEN: begin
          if (off_bad) begin
            push_cmd.op     = OP_STAT;
            push_cmd.status = ST_BAD_OFFSET;
            phase_nxt       = PH_FLAG;
          end else if (b > 8'(MAX_COPY - MIN_MATCH)) begin
            push_cmd.op     = OP_STAT;
            push_cmd.status = ST_BAD_LENGTH;
            phase_nxt       = PH_FLAG;
          end else begin
            push_cmd.op  = OP_COPY;
            push_cmd.len = LEN_W'(b) + LEN_W'(MIN_MATCH);
            add_amt      = push_cmd.len;
            add_en       = 1'b1;
            if (tok_idx_r == 3'd7) begin
              tok_idx_nxt = '0;
              phase_nxt   = PH_FLAG;
            end else begin
              tok_idx_nxt = tok_idx_r + 1'b1;
              phase_nxt   = PH_TOKEN;
            end
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end

    // bytes produced so far, saturating at the window size
    if (add_en) begin
      produced_nxt = (psum > (PC_W+1)'(HIST_DEPTH)) ? PC_W'(HIST_DEPTH) : psum[PC_W-1:0];
    end

    // end of stream returns to a fresh stream
    if (last_byte) begin
      phase_nxt    = PH_START;
      flags_nxt    = '0;
      tok_idx_nxt  = '0;
      off_hi_nxt   = '0;
      off_lo_nxt   = '0;
      rejected_nxt = 1'b0;
      produced_nxt = '0;
    end
  end

  assign push = accept && ((push_cmd.op != OP_NONE) || last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      flags_r    <= '0;
      tok_idx_r  <= '0;
      off_hi_r   <= '0;
      off_lo_r   <= '0;
      rejected_r <= 1'b0;
      produced_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      flags_r    <= flags_nxt;
      tok_idx_r  <= tok_idx_nxt;
      off_hi_r   <= off_hi_nxt;
      off_lo_r   <= off_lo_nxt;
      rejected_r <= rejected_nxt;
      produced_r <= produced_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_back.sv
`default_nettype none
module lzwd_back
  import lzwd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_head,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_COPY = 3'b010,
    BK_END  = 3'b100
  } bk_state_t;

  bk_state_t          state_r, state_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [HIST_AW-1:0] cp_src_r, cp_src_nxt;
  logic [LEN_W-1:0]   cp_left_r, cp_left_nxt;
  logic               cp_end_r, cp_end_nxt;
  logic               cp_full_r, cp_full_nxt;
  logic               dv_r, dv_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r;

  logic [7:0]         hist_mem [HIST_DEPTH];
  logic [7:0]         rd_data_r;
  logic               rd_en;
  logic               wr_en;
  logic [7:0]         wr_data;

  logic               can_emit;
  logic               emit;
  logic               emit_now;
  out_t               emit_data;
  logic [HIST_AW-1:0] wp_inc;
  logic [HIST_AW-1:0] src_inc;
  logic [TMP_W-1:0]   wp_ext;
  logic [TMP_W-1:0]   off_ext;
  logic [TMP_W-1:0]   src_w;

  assign can_emit = !out_valid_r || !out_stall;
  assign wp_inc   = (wp_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign src_inc  = (cp_src_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : cp_src_r + 1'b1;

  // copy source: write pointer minus offset, around the ring
  assign wp_ext  = TMP_W'(wp_r);
  assign off_ext = TMP_W'(q_head.off);
  assign src_w   = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                       : (wp_ext + TMP_W'(HIST_DEPTH) - off_ext);

  // command execution
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    cp_src_nxt  = cp_src_r;
    cp_left_nxt = cp_left_r;
    cp_end_nxt  = cp_end_r;
    cp_full_nxt = cp_full_r;
    dv_nxt      = dv_r;
    pop         = 1'b0;
    emit        = 1'b0;
    emit_now    = 1'b0;
    emit_data   = '{out_byte: 8'h00, status: ST_DATA, run_last: 1'b0};
    wr_en       = 1'b0;
    wr_data     = rd_data_r;
    rd_en       = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.op == OP_COPY) begin
            pop         = 1'b1;
            cp_src_nxt  = src_w[HIST_AW-1:0];
            cp_left_nxt = q_head.len;
            cp_end_nxt  = q_head.stream_end;
            cp_full_nxt = (int'(q_head.len) == RESULT_LIMIT);
            dv_nxt      = 1'b0;
            state_nxt   = BK_COPY;
          end else if (can_emit) begin
            pop  = 1'b1;
            emit = 1'b1;
            case (q_head.op)
              OP_LIT: begin
                emit_data.out_byte = q_head.lit;
                emit_data.run_last = !q_head.stream_end;
                wr_en              = 1'b1;
                wr_data            = q_head.lit;
                wp_nxt             = wp_inc;
              end
              OP_STAT: begin
                emit_data.status   = q_head.status;
                emit_data.run_last = !q_head.stream_end;
              end
              default: begin
                emit_data.status   = ST_END;
                emit_data.run_last = 1'b1;
              end
            endcase
            if (q_head.stream_end) begin
              wp_nxt = '0;
              if (q_head.op != OP_NONE) begin
                state_nxt = BK_END;
              end
            end
          end
        end
      end
      BK_COPY: begin
        // read one byte ahead while the previous one is written back
        emit_now = dv_r && can_emit;
        rd_en    = (cp_left_r != '0) && (!dv_r || emit_now);
        if (rd_en) begin
          cp_src_nxt  = src_inc;
          cp_left_nxt = cp_left_r - 1'b1;
        end
        dv_nxt = rd_en ? 1'b1 : (emit_now ? 1'b0 : dv_r);
        if (emit_now) begin
          emit               = 1'b1;
          emit_data.out_byte = rd_data_r;
          wr_en              = 1'b1;
          wp_nxt             = wp_inc;
          if (cp_left_r == '0) begin
            emit_data.run_last = !cp_end_r || cp_full_r;
            state_nxt          = (cp_end_r && !cp_full_r) ? BK_END : BK_IDLE;
            if (cp_end_r) begin
              wp_nxt = '0;
            end
          end
        end
      end
      BK_END: begin
        if (can_emit) begin
          emit               = 1'b1;
          emit_data.status   = ST_END;
          emit_data.run_last = 1'b1;
          state_nxt          = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wp_r        <= '0;
      cp_left_r   <= '0;
      cp_end_r    <= 1'b0;
      cp_full_r   <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cp_left_r   <= cp_left_nxt;
      cp_end_r    <= cp_end_nxt;
      cp_full_r   <= cp_full_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // copy source pointer and output beat register
  always_ff @(posedge clk) begin
    cp_src_r <= cp_src_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  // history window, read data forwarded when the same byte is being written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= (wr_en && (wp_r == cp_src_r)) ? wr_data : hist_mem[cp_src_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
